// ----- sv/sppq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppq_pkg
// Shared types, codes and defaults of the strict-priority paced queue.
// ----------------------------------------------------------------------------
package sppq_pkg;

   // Default sizes, handed to the top level parameters
   localparam int NUM_PRIORITIES_DEF = 8;
   localparam int FIFO_DEPTH_DEF     = 16;

   // Field widths
   localparam int ACTIVE_W   = 4;
   localparam int INTERVAL_W = 16;
   localparam int FPRIO_W    = 3;
   localparam int IPRIO_W    = 4;
   localparam int HANDLE_W   = 16;
   localparam int SPRIO_W    = 3;
   localparam int DROP_W     = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Configuration reset values
   localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET   = 4'd8;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_PRIO = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL    = 1'b1;

   // Item kind carried in tuser
   typedef enum logic {
      ACT_ENQUEUE = 1'b0,
      ACT_TICK    = 1'b1
   } action_type;

   // Drop reason of an enqueue
   typedef enum logic [DROP_W-1:0] {
      DROP_NONE    = 2'd0,
      DROP_INVALID = 2'd1,
      DROP_FULL    = 2'd2
   } drop_type;

   // Controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;   // input word taken this cycle
      logic load;     // move pending result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free; // output register empty or being drained
   } status_type;

endpackage

// ----- sv/sppq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sppq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sppq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppq_ctrl
// Controller: takes one input word, then hands its result to the output
// register before taking the next one.
// ----------------------------------------------------------------------------
module sppq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sppq_pkg::status_type  status,
   output sppq_pkg::cmd_type     cmd
);
   import sppq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_EMIT: begin
            cmd.load = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- sv/sppq_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppq_dp
// Datapath: configuration registers, per-priority FIFO pointers and counts,
// packet store, pacing countdown, pending result and output register.
// ----------------------------------------------------------------------------
module sppq_dp #(
   parameter int NUM_PRIORITIES = sppq_pkg::NUM_PRIORITIES_DEF,
   parameter int FIFO_DEPTH     = sppq_pkg::FIFO_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sppq_pkg::cmd_type                   cmd,
   output sppq_pkg::status_type                status,
   input  logic                                req_action,
   input  logic [sppq_pkg::FPRIO_W-1:0]        req_fprio,
   input  logic [sppq_pkg::IPRIO_W-1:0]        req_iprio,
   input  logic [sppq_pkg::HANDLE_W-1:0]       req_handle,
   input  logic                                csr_valid,
   input  logic [sppq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sppq_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sppq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import sppq_pkg::*;

   localparam int QW          = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
   localparam int LW          = $clog2(NUM_PRIORITIES + 1);
   localparam int PW          = $clog2(FIFO_DEPTH);
   localparam int CW          = $clog2(FIFO_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_PRIORITIES * FIFO_DEPTH;
   localparam int AW          = $clog2(STORE_DEPTH);

   // Configuration
   logic [ACTIVE_W-1:0]   active_ff;
   logic [INTERVAL_W-1:0] interval_ff;

   // Queue state
   logic [PW-1:0]         head_ff  [NUM_PRIORITIES];
   logic [PW-1:0]         head_in  [NUM_PRIORITIES];
   logic [PW-1:0]         tail_ff  [NUM_PRIORITIES];
   logic [PW-1:0]         tail_in  [NUM_PRIORITIES];
   logic [CW-1:0]         count_ff [NUM_PRIORITIES];
   logic [CW-1:0]         count_in [NUM_PRIORITIES];
   logic                  running_ff;
   logic                  running_in;
   logic [INTERVAL_W-1:0] countdown_ff;
   logic [INTERVAL_W-1:0] countdown_in;

   // Pending result
   logic                  pend_sv_ff;
   logic                  pend_sv_in;
   logic [SPRIO_W-1:0]    pend_sp_ff;
   logic [SPRIO_W-1:0]    pend_sp_in;
   drop_type              pend_drop_ff;
   drop_type              pend_drop_in;
   logic                  pend_busy_ff;
   logic                  pend_busy_in;

   // Output register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   // Combinational helpers
   logic [LW-1:0]         levels;
   logic [INTERVAL_W-1:0] reload;
   logic [INTERVAL_W-1:0] cd_dec;
   logic [NUM_PRIORITIES-1:0] served;
   logic [NUM_PRIORITIES-1:0] left_mask;
   logic                  found;
   logic [QW-1:0]         sel;
   logic                  frame_bad;
   logic                  iprio_ok;
   logic [IPRIO_W-1:0]    q_wide;
   logic [QW-1:0]         q;
   logic                  q_full;
   logic                  any_left;
   logic [7:0]            sel_ext;

   // Store ports
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [HANDLE_W-1:0]   ram_rd_data;

   sppq_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_handle),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= ACTIVE_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_PRIO: active_ff   <= csr_data[ACTIVE_W-1:0];
            CSR_INTERVAL:    interval_ff <= csr_data[INTERVAL_W-1:0];
            default:         active_ff   <= active_ff;
         endcase
      end
   end

   // Clamp level count, floor interval at one
   assign levels = (32'(active_ff) > NUM_PRIORITIES) ? LW'(NUM_PRIORITIES)
                                                     : LW'(active_ff);
   assign reload = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;
   assign cd_dec = (countdown_ff != '0) ? countdown_ff - INTERVAL_W'(1) : '0;

   // Pick the enqueue target
   assign frame_bad = 32'(req_fprio) >= 32'(levels);
   assign iprio_ok  = !req_iprio[IPRIO_W-1] &&
                      (32'(req_iprio[IPRIO_W-2:0]) < 32'(levels));
   assign q_wide    = iprio_ok ? {1'b0, req_iprio[IPRIO_W-2:0]} : {1'b0, req_fprio};
   assign q         = q_wide[QW-1:0];
   assign q_full    = count_ff[q] == CW'(FIFO_DEPTH);

   // Lowest-numbered active, non-empty queue
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
         served[i] = (count_ff[i] != '0) && (i < 32'(levels));
         if (served[i] && !found) begin
            found = 1'b1;
            sel   = QW'(i);
         end
      end
   end

   // Queues still holding packets after the pop
   always_comb begin
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
         left_mask[i] = served[i] &&
                        !(found && (sel == QW'(i)) && (count_ff[i] == CW'(1)));
      end
   end
   assign any_left = |left_mask;
   assign sel_ext  = 8'(sel);

   // Item processing
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      running_in   = running_ff;
      countdown_in = countdown_ff;
      pend_sv_in   = pend_sv_ff;
      pend_sp_in   = pend_sp_ff;
      pend_drop_in = pend_drop_ff;
      pend_busy_in = pend_busy_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = AW'(32'(q) * FIFO_DEPTH + 32'(tail_ff[q]));
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(32'(sel) * FIFO_DEPTH + 32'(head_ff[sel]));
      if (cmd.accept) begin
         pend_sv_in   = 1'b0;
         pend_sp_in   = '0;
         pend_drop_in = DROP_NONE;
         if (req_action == ACT_ENQUEUE) begin
            if (frame_bad) begin
               pend_drop_in = DROP_INVALID;
            end else if (q_full) begin
               pend_drop_in = DROP_FULL;
            end else begin
               ram_wr_en   = 1'b1;
               tail_in[q]  = (tail_ff[q] == PW'(FIFO_DEPTH - 1)) ? '0
                                                                : tail_ff[q] + PW'(1);
               count_in[q] = count_ff[q] + CW'(1);
               if (!running_ff) begin
                  running_in   = 1'b1;
                  countdown_in = reload;
               end
            end
         end else if (running_ff) begin
            countdown_in = cd_dec;
            if (cd_dec == '0) begin
               // Fire: send one packet, reload while work remains
               if (found) begin
                  ram_rd_en     = 1'b1;
                  head_in[sel]  = (head_ff[sel] == PW'(FIFO_DEPTH - 1)) ? '0
                                                                        : head_ff[sel] + PW'(1);
                  count_in[sel] = count_ff[sel] - CW'(1);
                  pend_sv_in    = 1'b1;
                  pend_sp_in    = sel_ext[SPRIO_W-1:0];
               end
               running_in   = any_left;
               countdown_in = any_left ? reload : '0;
            end
         end
         pend_busy_in = running_in;
      end
   end

   // Queue and pacing state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PRIORITIES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         running_ff   <= 1'b0;
         countdown_ff <= '0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         countdown_ff <= countdown_in;
      end
   end

   // Pending result
   always_ff @(posedge clock) begin
      pend_sv_ff   <= pend_sv_in;
      pend_sp_ff   <= pend_sp_in;
      pend_drop_ff <= pend_drop_in;
      pend_busy_ff <= pend_busy_in;
   end

   // Output register: load pending word, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, pend_busy_ff, pend_drop_ff, pend_sp_ff,
                         pend_sv_ff ? ram_rd_data : {HANDLE_W{1'b0}}, pend_sv_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // Countdown runs exactly while the block is busy
   a_busy_countdown: assert property (@(posedge clock) disable iff (reset)
      running_ff == (countdown_ff != '0))
      else $error("countdown and busy flag disagree");

   // A stored packet always leaves the block busy
   a_enq_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_action == ACT_ENQUEUE && !frame_bad && !q_full)
      |=> running_ff && pend_busy_ff)
      else $error("enqueue did not start the countdown");

   // A fire with a served queue yields a sent word
   a_fire_sends: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_action == ACT_TICK && running_ff && cd_dec == '0 && found)
      |=> pend_sv_ff && pend_drop_ff == DROP_NONE)
      else $error("fire with a waiting packet sent nothing");

   // Sent words carry no drop code
   a_sent_no_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.load && pend_sv_ff |=> rsp_tdata[RSP_DATA_W-3 -: DROP_W] == DROP_NONE)
      else $error("sent word carries a drop code");

endmodule

// ----- sv/strict_priority_paced_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_paced_queue
// Strict-priority egress queue with one FIFO per level, paced by base ticks.
// ----------------------------------------------------------------------------
// Each input word is either an enqueue or a base tick and returns exactly one
// result word. The block takes a word, updates the FIFO pointers, counts and
// countdown in that cycle, and then, in its emit state, loads the result into
// the output register once the output side is free; the packet store has one
// write and one registered read port, and the handle sent by a tick comes from
// that read. A stalled output holds the block in its emit state until the
// waiting word is taken. Configuration writes are accepted every cycle.
module strict_priority_paced_queue #(
   parameter int NUM_PRIORITIES = sppq_pkg::NUM_PRIORITIES_DEF,
   parameter int FIFO_DEPTH     = sppq_pkg::FIFO_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tuser: [0] action
   input  logic                             req_tuser,
   // tdata: [2:0] frame_priority, [6:3] internal_priority,
   //        [22:7] packet_handle, [23] zero
   input  logic [sppq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: [0] sent_valid, [16:1] sent_handle, [19:17] sent_priority,
   //        [21:20] drop_code, [22] busy_res, [23] zero
   output logic [sppq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sppq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sppq_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sppq_pkg::*;

   cmd_type    cmd;
   status_type status;

   sppq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sppq_dp #(
      .NUM_PRIORITIES (NUM_PRIORITIES),
      .FIFO_DEPTH     (FIFO_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_action (req_tuser),
      .req_fprio  (req_tdata[2:0]),
      .req_iprio  (req_tdata[6:3]),
      .req_handle (req_tdata[22:7]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Registers are always writable
   assign csr_ready = 1'b1;

endmodule
